FILE: sv/bhcs_pkg.sv
// types, constants and helpers for the bootloader host command sequencer
package bhcs_pkg;

  localparam int unsigned MAX_LENGTH  = 32768;
  localparam int unsigned WRITE_CHUNK = 128;
  localparam int unsigned READ_CHUNK  = 256;
  localparam int unsigned MAX_RES     = 6;
  localparam int unsigned CNT_W       = $clog2(MAX_RES + 1);
  localparam int unsigned CHUNK_W     = 9;

  localparam logic [7:0]  ACK_BYTE      = 8'h79;
  localparam logic [7:0]  OPC_WRITE     = 8'h31;
  localparam logic [7:0]  OPC_READ      = 8'h11;
  localparam logic [7:0]  OPC_GO        = 8'h21;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  typedef enum logic [2:0] {
    CMD_BEGIN_WRITE = 3'd0,
    CMD_PAYLOAD     = 3'd1,
    CMD_BEGIN_READ  = 3'd2,
    CMD_BEGIN_GO    = 3'd3,
    CMD_RX_BYTE     = 3'd4,
    CMD_TICK        = 3'd5,
    CMD_CANCEL      = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ACK_OP    = 3'd1,
    PH_ACK_ADDR  = 3'd2,
    PH_PAYLOAD   = 3'd3,
    PH_ACK_DATA  = 3'd4,
    PH_ACK_LEN   = 3'd5,
    PH_READ_DATA = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_GO    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_RX     = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NACK     = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_CANCELED = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
  } result_t;

  function automatic logic [7:0] op_code(op_t op);
    unique case (op)
      OP_WRITE: op_code = OPC_WRITE;
      OP_READ:  op_code = OPC_READ;
      default:  op_code = OPC_GO;
    endcase
  endfunction

  function automatic result_t tx_res(logic [7:0] b);
    tx_res = '{kind: KIND_TX, data: b, status: ST_OK};
  endfunction

  function automatic result_t st_res(status_t s);
    st_res = '{kind: KIND_STATUS, data: 8'h00, status: s};
  endfunction

endpackage

FILE: sv/bootloader_host_command_sequencer_top.sv
// bootloader host command sequencer: command decode, state and result queue
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser cmd, tdata address/length/byte_in
//  m_*       out  m_tvalid/m_tready  tuser kind, tdata byte_out/status, tlast
//  cfg_*     in   cfg_we             cfg_wdata timeout_ticks
//
// each beat is decoded into up to six results held in a small shift queue;
// results leave one per cycle while m_tready is high. cancel beats and ticks
// that do not time out give no result and are taken every cycle while the
// queue is empty. a new beat is taken while the final queued result leaves.
// synchronous reset empties the queue and puts the sequencer idle with a
// timeout of 2000 ticks.
module bootloader_host_command_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // address[31:0], length[47:32], byte_in[55:48]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // byte_out[7:0], status[10:8], zero[15:11]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import bhcs_pkg::*;

  logic [15:0]      timeout_ticks;
  phase_t           phase, phase_next;
  op_t              operation, operation_next;
  logic [31:0]      current_address, current_address_next;
  logic [15:0]      bytes_remaining, bytes_remaining_next;
  logic [8:0]       chunk_bytes_left, chunk_bytes_left_next;
  logic [7:0]       running_checksum, running_checksum_next;
  logic [15:0]      wait_ticks, wait_ticks_next;
  logic             cancel_pending, cancel_pending_next;

  result_t          res_q [MAX_RES];
  result_t          res_next [MAX_RES];
  logic [CNT_W-1:0] res_cnt;
  logic [CNT_W-1:0] nres;

  cmd_t             cmd;
  logic [31:0]      in_address;
  logic [15:0]      in_length;
  logic [7:0]       in_byte;
  logic             accept, take;
  logic             len_bad;
  op_t              op_new;
  logic [7:0]       opc;
  logic [7:0]       addr_xor;
  logic [8:0]       chunk;
  logic [8:0]       chunk_m1;
  logic [8:0]       cbl_dec;
  logic [7:0]       cs_new;
  logic [15:0]      wt_inc;

  assign cmd        = cmd_t'(s_tuser);
  assign in_address = s_tdata[31:0];
  assign in_length  = s_tdata[47:32];
  assign in_byte    = s_tdata[55:48];

  assign m_tvalid = (res_cnt != '0);
  assign m_tlast  = (res_cnt == CNT_W'(1));
  assign m_tdata  = {5'b0, res_q[0].status, res_q[0].data};
  assign m_tuser  = res_q[0].kind;
  assign take     = m_tvalid && m_tready;
  assign s_tready = (res_cnt == '0) || (m_tlast && m_tready);
  assign accept   = s_tvalid && s_tready;

  assign len_bad  = (in_length == 16'd0) || ({1'b0, in_length} > 17'(MAX_LENGTH));
  assign addr_xor = current_address[31:24] ^ current_address[23:16] ^
                    current_address[15:8] ^ current_address[7:0];
  assign cbl_dec  = chunk_bytes_left - 9'd1;
  assign cs_new   = running_checksum ^ in_byte;
  assign wt_inc   = (wait_ticks != 16'hFFFF) ? wait_ticks + 16'd1 : wait_ticks;

  always_comb begin
    if (operation == OP_WRITE) begin
      chunk = (bytes_remaining < 16'(WRITE_CHUNK)) ? bytes_remaining[8:0] : CHUNK_W'(WRITE_CHUNK);
    end else begin
      chunk = (bytes_remaining < 16'(READ_CHUNK)) ? bytes_remaining[8:0] : CHUNK_W'(READ_CHUNK);
    end
    chunk_m1 = chunk - 9'd1;
  end

  always_comb begin
    phase_next            = phase;
    operation_next        = operation;
    current_address_next  = current_address;
    bytes_remaining_next  = bytes_remaining;
    chunk_bytes_left_next = chunk_bytes_left;
    running_checksum_next = running_checksum;
    wait_ticks_next       = wait_ticks;
    cancel_pending_next   = cancel_pending;
    for (int k = 0; k < MAX_RES; k++) begin
      res_next[k] = '0;
    end
    nres   = '0;
    op_new = OP_WRITE;
    opc    = op_code(operation);

    unique case (cmd)
      CMD_BEGIN_WRITE, CMD_BEGIN_READ, CMD_BEGIN_GO: begin
        if (phase != PH_IDLE || (cmd != CMD_BEGIN_GO && len_bad)) begin
          res_next[nres] = st_res(ST_REJECTED); nres = nres + 1'b1;
        end else begin
          if (cmd == CMD_BEGIN_WRITE) begin
            op_new = OP_WRITE;
          end else if (cmd == CMD_BEGIN_READ) begin
            op_new = OP_READ;
          end else begin
            op_new = OP_GO;
          end
          operation_next        = op_new;
          current_address_next  = in_address;
          bytes_remaining_next  = (cmd == CMD_BEGIN_GO) ? 16'd0 : in_length;
          chunk_bytes_left_next = '0;
          running_checksum_next = '0;
          cancel_pending_next   = 1'b0;
          opc = op_code(op_new);
          res_next[nres] = tx_res(opc); nres = nres + 1'b1;
          res_next[nres] = tx_res(~opc); nres = nres + 1'b1;
          phase_next      = PH_ACK_OP;
          wait_ticks_next = '0;
        end
      end
      CMD_PAYLOAD: begin
        if (phase != PH_PAYLOAD || chunk_bytes_left == '0) begin
          res_next[nres] = st_res(ST_REJECTED); nres = nres + 1'b1;
        end else begin
          res_next[nres] = tx_res(in_byte); nres = nres + 1'b1;
          running_checksum_next = cs_new;
          chunk_bytes_left_next = cbl_dec;
          if (cbl_dec == '0) begin
            res_next[nres] = tx_res(cs_new); nres = nres + 1'b1;
            phase_next      = PH_ACK_DATA;
            wait_ticks_next = '0;
            if (cancel_pending) begin
              res_next[nres] = st_res(ST_CANCELED); nres = nres + 1'b1;
              phase_next = PH_IDLE; cancel_pending_next = 1'b0;
            end
          end
        end
      end
      CMD_RX_BYTE: begin
        if (phase == PH_ACK_OP || phase == PH_ACK_ADDR ||
            phase == PH_ACK_DATA || phase == PH_ACK_LEN) begin
          wait_ticks_next = '0;
          if (in_byte != ACK_BYTE) begin
            res_next[nres] = st_res(ST_NACK); nres = nres + 1'b1;
            phase_next = PH_IDLE; cancel_pending_next = 1'b0;
            chunk_bytes_left_next = '0;
          end else begin
            unique case (phase)
              PH_ACK_OP: begin
                res_next[nres] = tx_res(current_address[31:24]); nres = nres + 1'b1;
                res_next[nres] = tx_res(current_address[23:16]); nres = nres + 1'b1;
                res_next[nres] = tx_res(current_address[15:8]);  nres = nres + 1'b1;
                res_next[nres] = tx_res(current_address[7:0]);   nres = nres + 1'b1;
                res_next[nres] = tx_res(addr_xor);               nres = nres + 1'b1;
                phase_next = PH_ACK_ADDR;
                if (cancel_pending) begin
                  res_next[nres] = st_res(ST_CANCELED); nres = nres + 1'b1;
                  phase_next = PH_IDLE; cancel_pending_next = 1'b0;
                  chunk_bytes_left_next = '0;
                end
              end
              PH_ACK_ADDR: begin
                if (operation == OP_GO) begin
                  res_next[nres] = st_res(ST_OK); nres = nres + 1'b1;
                  phase_next = PH_IDLE; cancel_pending_next = 1'b0;
                  chunk_bytes_left_next = '0;
                end else begin
                  bytes_remaining_next  = bytes_remaining - 16'(chunk);
                  chunk_bytes_left_next = chunk;
                  res_next[nres] = tx_res(chunk_m1[7:0]); nres = nres + 1'b1;
                  if (operation == OP_WRITE) begin
                    running_checksum_next = chunk_m1[7:0];
                    phase_next = PH_PAYLOAD;
                  end else begin
                    res_next[nres] = tx_res(~chunk_m1[7:0]); nres = nres + 1'b1;
                    phase_next = PH_ACK_LEN;
                    if (cancel_pending) begin
                      res_next[nres] = st_res(ST_CANCELED); nres = nres + 1'b1;
                      phase_next = PH_IDLE; cancel_pending_next = 1'b0;
                      chunk_bytes_left_next = '0;
                    end
                  end
                end
              end
              PH_ACK_DATA: begin
                if (bytes_remaining == '0) begin
                  res_next[nres] = st_res(ST_OK); nres = nres + 1'b1;
                  phase_next = PH_IDLE; cancel_pending_next = 1'b0;
                  chunk_bytes_left_next = '0;
                end else begin
                  current_address_next = current_address + 32'(WRITE_CHUNK);
                  res_next[nres] = tx_res(opc); nres = nres + 1'b1;
                  res_next[nres] = tx_res(~opc); nres = nres + 1'b1;
                  phase_next = PH_ACK_OP;
                  if (cancel_pending) begin
                    res_next[nres] = st_res(ST_CANCELED); nres = nres + 1'b1;
                    phase_next = PH_IDLE; cancel_pending_next = 1'b0;
                    chunk_bytes_left_next = '0;
                  end
                end
              end
              default: begin
                phase_next = PH_READ_DATA;
              end
            endcase
          end
        end else if (phase == PH_READ_DATA && chunk_bytes_left != '0) begin
          res_next[nres] = '{kind: KIND_RX, data: in_byte, status: ST_OK};
          nres = nres + 1'b1;
          wait_ticks_next       = '0;
          chunk_bytes_left_next = cbl_dec;
          if (cbl_dec == '0) begin
            if (bytes_remaining == '0) begin
              res_next[nres] = st_res(ST_OK); nres = nres + 1'b1;
              phase_next = PH_IDLE; cancel_pending_next = 1'b0;
            end else begin
              current_address_next = current_address + 32'(READ_CHUNK);
              res_next[nres] = tx_res(opc); nres = nres + 1'b1;
              res_next[nres] = tx_res(~opc); nres = nres + 1'b1;
              phase_next = PH_ACK_OP;
              if (cancel_pending) begin
                res_next[nres] = st_res(ST_CANCELED); nres = nres + 1'b1;
                phase_next = PH_IDLE; cancel_pending_next = 1'b0;
              end
            end
          end
        end else begin
          res_next[nres] = st_res(ST_REJECTED); nres = nres + 1'b1;
        end
      end
      CMD_TICK: begin
        if (phase != PH_IDLE && phase != PH_PAYLOAD) begin
          if (wt_inc >= timeout_ticks) begin
            res_next[nres] = st_res(ST_TIMEOUT); nres = nres + 1'b1;
            phase_next = PH_IDLE; cancel_pending_next = 1'b0;
            wait_ticks_next = '0; chunk_bytes_left_next = '0;
          end else begin
            wait_ticks_next = wt_inc;
          end
        end
      end
      CMD_CANCEL: begin
        if (phase != PH_IDLE) begin
          cancel_pending_next = 1'b1;
        end
      end
      default: begin
        res_next[nres] = st_res(ST_REJECTED); nres = nres + 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks    <= TIMEOUT_RESET;
      phase            <= PH_IDLE;
      operation        <= OP_WRITE;
      current_address  <= '0;
      bytes_remaining  <= '0;
      chunk_bytes_left <= '0;
      running_checksum <= '0;
      wait_ticks       <= '0;
      cancel_pending   <= 1'b0;
      res_cnt          <= '0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
      if (accept) begin
        phase            <= phase_next;
        operation        <= operation_next;
        current_address  <= current_address_next;
        bytes_remaining  <= bytes_remaining_next;
        chunk_bytes_left <= chunk_bytes_left_next;
        running_checksum <= running_checksum_next;
        wait_ticks       <= wait_ticks_next;
        cancel_pending   <= cancel_pending_next;
        res_cnt          <= nres;
      end else if (take) begin
        res_cnt <= res_cnt - 1'b1;
      end
    end
  end

  // result queue, head always in slot 0
  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_next;
    end else if (take) begin
      for (int k = 0; k < MAX_RES - 1; k++) begin
        res_q[k] <= res_q[k + 1];
      end
    end
  end

  a_res_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= CNT_W'(MAX_RES))
    else $error("result queue count out of range");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_STATUS |-> m_tlast)
    else $error("status beat not last of its item");

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> chunk_bytes_left != '0)
    else $error("payload phase with empty chunk");

  a_write_opcode: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_BEGIN_WRITE && phase == PH_IDLE && !len_bad
    |=> m_tvalid && m_tuser == KIND_TX && m_tdata[7:0] == OPC_WRITE)
    else $error("begin write did not start with write opcode");

endmodule

FILE: verif/bootloader_host_command_sequencer_top_tb.sv
// self-checking testbench for the bootloader host command sequencer top level
module bootloader_host_command_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bhcs_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int LATENCY_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;

  typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_SLOW} rx_mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
    logic       last;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // address[31:0], length[47:32], byte_in[55:48]
  logic [2:0]  s_tuser = '0;   // cmd[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // byte_out[7:0], status[10:8], zero[15:11]
  logic [1:0]  m_tuser;        // kind[1:0]
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // sequencer state as predicted
  phase_t      seq_phase = PH_IDLE;
  op_t         seq_op = OP_WRITE;
  logic [31:0] seq_addr = '0;
  logic [15:0] seq_remaining = '0;
  logic [8:0]  seq_chunk_left = '0;
  logic [7:0]  seq_xsum = '0;
  logic [15:0] seq_ticks = '0;
  logic        seq_cancel = 1'b0;
  logic [15:0] seq_timeout = TIMEOUT_RESET;

  out_beat_t   step_out_q[$];
  out_beat_t   host_out_q[$];

  int          fault_count = 0;
  int          beats_sent = 0;
  int          burst_left = 0;
  bit          steady_send = 1'b0;
  bit          doomed = 1'b0;
  int          hold_request_cycles = 0;

  bootloader_host_command_sequencer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void put_out(kind_t k, logic [7:0] d, status_t s);
    out_beat_t o;
    o.kind = k;
    o.data = d;
    o.status = s;
    o.last = 1'b0;
    step_out_q.push_back(o);
  endfunction

  function automatic void close_cmd(status_t s);
    put_out(KIND_STATUS, 8'h00, s);
    seq_phase = PH_IDLE;
    seq_cancel = 1'b0;
    seq_ticks = '0;
    seq_chunk_left = '0;
  endfunction

  function automatic void arm_wait(phase_t p);
    seq_phase = p;
    seq_ticks = '0;
    if (seq_cancel) close_cmd(ST_CANCELED);
  endfunction

  function automatic void send_opcode();
    logic [7:0] oc;
    if (seq_op == OP_WRITE) oc = OPC_WRITE;
    else if (seq_op == OP_READ) oc = OPC_READ;
    else oc = OPC_GO;
    put_out(KIND_TX, oc, ST_OK);
    put_out(KIND_TX, oc ^ 8'hFF, ST_OK);
    arm_wait(PH_ACK_OP);
  endfunction

  function automatic logic [8:0] take_chunk(logic [8:0] size);
    logic [15:0] c;
    c = (seq_remaining < 16'(size)) ? seq_remaining : 16'(size);
    seq_remaining = seq_remaining - c;
    seq_chunk_left = c[8:0];
    return c[8:0];
  endfunction

  function automatic bit awaiting_ack();
    return seq_phase == PH_ACK_OP || seq_phase == PH_ACK_ADDR ||
           seq_phase == PH_ACK_DATA || seq_phase == PH_ACK_LEN;
  endfunction

  // works out the result beats of one accepted command beat
  function automatic void sequence_command(logic [2:0] cmd, logic [31:0] addr,
                                           logic [15:0] len, logic [7:0] b);
    logic [8:0] c9;
    out_beat_t  o;
    step_out_q.delete();
    case (cmd)
      CMD_BEGIN_WRITE, CMD_BEGIN_READ, CMD_BEGIN_GO: begin
        if (seq_phase != PH_IDLE ||
            (cmd != CMD_BEGIN_GO && (len == 0 || len > MAX_LENGTH))) begin
          put_out(KIND_STATUS, 8'h00, ST_REJECTED);
        end else begin
          if (cmd == CMD_BEGIN_WRITE) seq_op = OP_WRITE;
          else if (cmd == CMD_BEGIN_READ) seq_op = OP_READ;
          else seq_op = OP_GO;
          seq_addr = addr;
          seq_remaining = (cmd == CMD_BEGIN_GO) ? 16'd0 : len;
          seq_chunk_left = '0;
          seq_xsum = '0;
          seq_cancel = 1'b0;
          send_opcode();
        end
      end
      CMD_PAYLOAD: begin
        if (seq_phase != PH_PAYLOAD || seq_chunk_left == 0) begin
          put_out(KIND_STATUS, 8'h00, ST_REJECTED);
        end else begin
          put_out(KIND_TX, b, ST_OK);
          seq_xsum = seq_xsum ^ b;
          seq_chunk_left = seq_chunk_left - 9'd1;
          if (seq_chunk_left == 0) begin
            put_out(KIND_TX, seq_xsum, ST_OK);
            arm_wait(PH_ACK_DATA);
          end
        end
      end
      CMD_RX_BYTE: begin
        if (awaiting_ack()) begin
          seq_ticks = '0;
          if (b != ACK_BYTE) begin
            close_cmd(ST_NACK);
          end else begin
            case (seq_phase)
              PH_ACK_OP: begin
                put_out(KIND_TX, seq_addr[31:24], ST_OK);
                put_out(KIND_TX, seq_addr[23:16], ST_OK);
                put_out(KIND_TX, seq_addr[15:8], ST_OK);
                put_out(KIND_TX, seq_addr[7:0], ST_OK);
                put_out(KIND_TX, seq_addr[31:24] ^ seq_addr[23:16] ^
                                 seq_addr[15:8] ^ seq_addr[7:0], ST_OK);
                arm_wait(PH_ACK_ADDR);
              end
              PH_ACK_ADDR: begin
                if (seq_op == OP_WRITE) begin
                  c9 = take_chunk(9'(WRITE_CHUNK)) - 9'd1;
                  seq_xsum = c9[7:0];
                  put_out(KIND_TX, seq_xsum, ST_OK);
                  seq_phase = PH_PAYLOAD;
                end else if (seq_op == OP_READ) begin
                  c9 = take_chunk(9'(READ_CHUNK)) - 9'd1;
                  put_out(KIND_TX, c9[7:0], ST_OK);
                  put_out(KIND_TX, c9[7:0] ^ 8'hFF, ST_OK);
                  arm_wait(PH_ACK_LEN);
                end else begin
                  close_cmd(ST_OK);
                end
              end
              PH_ACK_DATA: begin
                if (seq_remaining == 0) begin
                  close_cmd(ST_OK);
                end else begin
                  seq_addr = seq_addr + 32'(WRITE_CHUNK);
                  send_opcode();
                end
              end
              default: begin
                seq_phase = PH_READ_DATA;
                seq_ticks = '0;
              end
            endcase
          end
        end else if (seq_phase == PH_READ_DATA && seq_chunk_left != 0) begin
          put_out(KIND_RX, b, ST_OK);
          seq_ticks = '0;
          seq_chunk_left = seq_chunk_left - 9'd1;
          if (seq_chunk_left == 0) begin
            if (seq_remaining == 0) begin
              close_cmd(ST_OK);
            end else begin
              seq_addr = seq_addr + 32'(READ_CHUNK);
              send_opcode();
            end
          end
        end else begin
          put_out(KIND_STATUS, 8'h00, ST_REJECTED);
        end
      end
      CMD_TICK: begin
        if (awaiting_ack() || seq_phase == PH_READ_DATA) begin
          if (seq_ticks != 16'hFFFF) seq_ticks = seq_ticks + 16'd1;
          if (seq_ticks >= seq_timeout) close_cmd(ST_TIMEOUT);
        end
      end
      CMD_CANCEL: begin
        if (seq_phase != PH_IDLE) seq_cancel = 1'b1;
      end
      default: begin
        put_out(KIND_STATUS, 8'h00, ST_REJECTED);
      end
    endcase
    foreach (step_out_q[i]) begin
      o = step_out_q[i];
      o.last = (i == step_out_q.size() - 1);
      host_out_q.push_back(o);
    end
  endfunction

  task automatic send_beat(input logic [2:0] cmd, input logic [31:0] addr,
                           input logic [15:0] len, input logic [7:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {b, len, addr};
    do @(posedge clk); while (!s_tready);
    sequence_command(cmd, addr, len, b);
    beats_sent++;
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] b);
    send_beat(cmd, $urandom, 16'($urandom), b);
  endtask

  task automatic send_nack();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ACK_BYTE);
    send_cmd(CMD_RX_BYTE, b);
  endtask

  task automatic send_any();
    logic [2:0] c;
    c = 3'($urandom_range(0, 7));
    // an arbitrary begin may carry a huge length, so it gets aborted
    if (seq_phase == PH_IDLE) doomed = 1'b1;
    send_beat(c, $urandom, 16'($urandom), 8'($urandom));
  endtask

  task automatic send_begin(input logic [2:0] c);
    logic [15:0] len;
    int r;
    r = $urandom_range(0, 99);
    if (seq_phase == PH_IDLE) doomed = 1'b0;
    if (r < 70) begin
      len = 16'($urandom_range(1, 6));
    end else if (r < 88) begin
      len = 16'($urandom_range(7, 24));
    end else if (r < 95) begin
      len = 16'($urandom_range(25, MAX_LENGTH));
      if (seq_phase == PH_IDLE) doomed = 1'b1;
    end else if (r < 97) begin
      len = 16'd0;
    end else begin
      len = 16'($urandom_range(MAX_LENGTH + 1, 16'hFFFF));
    end
    send_beat(c, $urandom, len, 8'($urandom));
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (seq_phase == PH_IDLE) begin
      if (r < 30) send_begin(CMD_BEGIN_WRITE);
      else if (r < 55) send_begin(CMD_BEGIN_READ);
      else if (r < 68) send_begin(CMD_BEGIN_GO);
      else send_any();
    end else if (awaiting_ack() && doomed) begin
      if (r < 35) send_nack();
      else if (r < 55) send_cmd(CMD_CANCEL, 8'($urandom));
      else if (r < 75) send_cmd(CMD_TICK, 8'($urandom));
      else if (r < 85 && seq_phase != PH_ACK_ADDR) send_cmd(CMD_RX_BYTE, ACK_BYTE);
      else send_any();
    end else if (awaiting_ack()) begin
      if (r < 72) begin
        send_cmd(CMD_RX_BYTE, ACK_BYTE);
      end else if (r < 78) begin
        send_nack();
      end else if (r < 84) begin
        send_cmd(CMD_TICK, 8'($urandom));
      end else if (r < 88) begin
        send_cmd(CMD_CANCEL, 8'($urandom));
      end else if (r < 93) begin
        case ($urandom_range(0, 2))
          0: send_begin(CMD_BEGIN_WRITE);
          1: send_begin(CMD_BEGIN_READ);
          default: send_begin(CMD_BEGIN_GO);
        endcase
      end else begin
        send_any();
      end
    end else if (seq_phase == PH_PAYLOAD) begin
      if (r < 88) send_cmd(CMD_PAYLOAD, 8'($urandom));
      else if (r < 92) send_cmd(CMD_TICK, 8'($urandom));
      else if (r < 95) send_cmd(CMD_CANCEL, 8'($urandom));
      else send_any();
    end else begin
      if (r < 86) send_cmd(CMD_RX_BYTE, 8'($urandom));
      else if (r < 92) send_cmd(CMD_TICK, 8'($urandom));
      else if (r < 95) send_cmd(CMD_CANCEL, 8'($urandom));
      else send_any();
    end
  endtask

  task automatic random_traffic(input int n);
    int first;
    first = beats_sent;
    while (beats_sent - first < n) random_step();
  endtask

  // finish the running command, acknowledging everything or refusing at the next wait
  task automatic run_to_idle(input bit ack_all);
    while (seq_phase != PH_IDLE) begin
      if (awaiting_ack()) begin
        if (!ack_all) send_nack();
        else if (seq_timeout > 4 && $urandom_range(0, 9) == 0) send_cmd(CMD_TICK, 8'($urandom));
        else send_cmd(CMD_RX_BYTE, ACK_BYTE);
      end else if (seq_phase == PH_PAYLOAD) begin
        send_cmd(CMD_PAYLOAD, 8'($urandom));
      end else begin
        send_cmd(CMD_RX_BYTE, 8'($urandom));
      end
    end
  endtask

  task automatic idle_input();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    idle_input();
    while (host_out_q.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    seq_timeout = v;
  endtask

  task automatic test_go_command();
    send_beat(CMD_BEGIN_GO, 32'hFFFF_FFFF, 16'($urandom), 8'($urandom));
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_beat(CMD_BEGIN_GO, 32'h0000_0000, 16'($urandom), 8'($urandom));
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_RX_BYTE, 8'h1F);
  endtask

  task automatic test_single_write();
    send_beat(CMD_BEGIN_WRITE, 32'h0000_0000, 16'd1, 8'($urandom));
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_PAYLOAD, 8'hFF);
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
  endtask

  task automatic test_short_read();
    send_beat(CMD_BEGIN_READ, 32'h8000_0001, 16'd2, 8'($urandom));
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_RX_BYTE, 8'h00);
    send_cmd(CMD_RX_BYTE, 8'hFF);
  endtask

  task automatic test_rejects_and_cancel();
    send_cmd(CMD_UNUSED, 8'($urandom));
    send_cmd(CMD_PAYLOAD, 8'($urandom));
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_TICK, 8'($urandom));
    send_cmd(CMD_CANCEL, 8'($urandom));
    send_beat(CMD_BEGIN_WRITE, $urandom, 16'd0, 8'($urandom));
    send_beat(CMD_BEGIN_READ, $urandom, 16'hFFFF, 8'($urandom));
    // largest length is taken, then a pending cancel ends it after the address
    send_beat(CMD_BEGIN_WRITE, $urandom, 16'(MAX_LENGTH), 8'($urandom));
    send_beat(CMD_BEGIN_READ, $urandom, 16'd4, 8'($urandom));
    send_cmd(CMD_CANCEL, 8'($urandom));
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
  endtask

  task automatic test_rx_timeout();
    run_to_idle(1'b0);
    write_timeout(16'd1);
    send_beat(CMD_BEGIN_GO, $urandom, 16'($urandom), 8'($urandom));
    send_cmd(CMD_TICK, 8'($urandom));
    write_timeout(16'd3);
    send_beat(CMD_BEGIN_READ, $urandom, 16'd2, 8'($urandom));
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_RX_BYTE, ACK_BYTE);
    send_cmd(CMD_TICK, 8'($urandom));
    send_cmd(CMD_TICK, 8'($urandom));
    send_cmd(CMD_RX_BYTE, 8'h5A);
    send_cmd(CMD_TICK, 8'($urandom));
    send_cmd(CMD_TICK, 8'($urandom));
    send_cmd(CMD_TICK, 8'($urandom));
  endtask

  task automatic test_chunk_crossing();
    run_to_idle(1'b0);
    send_beat(CMD_BEGIN_WRITE, $urandom,
              16'($urandom_range(WRITE_CHUNK + 1, WRITE_CHUNK + 3)), 8'($urandom));
    run_to_idle(1'b1);
  endtask

  task automatic test_backpressure();
    run_to_idle(1'b0);
    hold_request_cycles = HOLD_CYCLES;
    steady_send = 1'b1;
    random_traffic(30);
    steady_send = 1'b0;
    run_to_idle(1'b0);
  endtask

  task automatic test_random_traffic();
    run_to_idle(1'b0);
    write_timeout(16'hFFFF);
    random_traffic(40);
    run_to_idle(1'b0);
    write_timeout(16'd1);
    random_traffic(40);
    run_to_idle(1'b0);
    write_timeout(16'($urandom_range(2, 6)));
    random_traffic(40);
    run_to_idle(1'b0);
  endtask

  // receiver: changing ready patterns, plus long hold-offs on request
  initial begin : ready_pattern
    int stall_left;
    int window_left;
    int cycle_no;
    rx_mode_t mode;
    stall_left = 0;
    window_left = 0;
    cycle_no = 0;
    mode = RX_FREE;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (hold_request_cycles != 0) begin
        stall_left = hold_request_cycles;
        hold_request_cycles = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        if (window_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          window_left = $urandom_range(8, 60);
        end
        window_left--;
        case (mode)
          RX_FREE:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: m_tready <= ($urandom_range(0, 4) != 0);
          default:   m_tready <= (cycle_no % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : out_check
    out_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (host_out_q.size() == 0) begin
        $error("unexpected result beat: kind %0d byte %0h status %0d", m_tuser,
               m_tdata[7:0], m_tdata[10:8]);
        fault_count++;
      end else begin
        want = host_out_q.pop_front();
        if (m_tuser !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
          fault_count++;
        end
        if (m_tdata[7:0] !== want.data) begin
          $error("byte_out: expected %0h, actual %0h", want.data, m_tdata[7:0]);
          fault_count++;
        end
        if (m_tdata[10:8] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[10:8]);
          fault_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_tlast);
          fault_count++;
        end
      end
    end
  end

  initial begin : run_tests
    int drain_guard;
    drain_guard = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_go_command();
    test_single_write();
    test_short_read();
    test_rejects_and_cancel();
    test_rx_timeout();
    test_chunk_crossing();
    test_backpressure();
    test_random_traffic();
    idle_input();
    while (host_out_q.size() != 0 && drain_guard < 50000) begin
      @(posedge clk);
      drain_guard++;
    end
    if (host_out_q.size() != 0) begin
      $error("%0d result beats never arrived", host_out_q.size());
      fault_count++;
    end
    repeat (LATENCY_CYCLES * 4) @(posedge clk);
    if (fault_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
